@@ hdl/idof_pkg.sv @@
package idof_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned SCORE_BITS = 14;
  localparam int unsigned IDX_BITS   = 6;
  localparam int unsigned MODE_BITS  = 2;

  localparam logic [MODE_BITS-1:0] MODE_EXACT   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BEST    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLUSTER = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_NONE    = 2'd3;

  typedef struct packed {
    logic ent_we;
    logic rem_we;
    logic rem_wdata;
    logic rd_en;
  } store_ctl_t;

endpackage

@@ hdl/idof_if.sv @@
interface idof_in_if import idof_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_pos;
  logic [COORD_BITS-1:0] end_pos;
  logic [SCORE_BITS-1:0] score;
  logic                  removed_in;
  logic                  last_in;

  modport source (output valid, start_pos, end_pos, score, removed_in, last_in, input ready);
  modport sink (input valid, start_pos, end_pos, score, removed_in, last_in, output ready);
endinterface

interface idof_out_if import idof_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IDX_BITS-1:0]   entry_index;
  logic [COORD_BITS-1:0] start_out;
  logic [COORD_BITS-1:0] end_out;
  logic                  removed_out;
  logic                  overflowed;
  logic                  last_out;

  modport source (output valid, entry_index, start_out, end_out, removed_out, overflowed,
                  last_out, input ready);
  modport sink (input valid, entry_index, start_out, end_out, removed_out, overflowed,
                last_out, output ready);
endinterface

interface idof_cfg_if import idof_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;

  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

@@ hdl/interval_duplicate_overlap_filter_top.sv @@
// loading: ready stays high, so input transfers never wait; results follow the last input
// filter pass (not in mode none): a live entry a scans later entries, then writes its flag
// emission: one result per cycle after a first read, while out_o is ready (single read port)
// reset clears control, counters, mode and span; entry memories stay undefined, no clearing pass
module interval_duplicate_overlap_filter_top import idof_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned POS_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  idof_cfg_if.sink    cfg_i,
  idof_in_if.sink     in_i,
  idof_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [MODE_BITS-1:0]  mode_q;
  store_ctl_t            st_ctl;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [POS_BITS-1:0]   wstart, wend;
  logic [SCORE_BITS-1:0] wscore;
  logic [POS_BITS-1:0]   rd_start, rd_end;
  logic [SCORE_BITS-1:0] rd_score;
  logic                  rd_rem;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EXACT;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.mode;
    end
  end

  idof_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .POS_BITS    (POS_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_ch      (in_i),
    .out_ch     (out_o),
    .st_ctl_o   (st_ctl),
    .waddr_o    (waddr),
    .raddr_o    (raddr),
    .wstart_o   (wstart),
    .wend_o     (wend),
    .wscore_o   (wscore),
    .rd_start_i (rd_start),
    .rd_end_i   (rd_end),
    .rd_score_i (rd_score),
    .rd_rem_i   (rd_rem)
  );

  idof_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .POS_BITS    (POS_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (st_ctl),
    .waddr_i    (waddr),
    .raddr_i    (raddr),
    .start_i    (wstart),
    .end_i      (wend),
    .score_i    (wscore),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end),
    .rd_score_o (rd_score),
    .rd_rem_o   (rd_rem)
  );

endmodule

@@ hdl/idof_store.sv @@
module idof_store import idof_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned POS_BITS    = 32,
  localparam int unsigned IW         = $clog2(MAX_ENTRIES)
) (
  input  logic                  clk_i,
  input  store_ctl_t            ctl_i,
  input  logic [IW-1:0]         waddr_i,
  input  logic [IW-1:0]         raddr_i,
  input  logic [POS_BITS-1:0]   start_i,
  input  logic [POS_BITS-1:0]   end_i,
  input  logic [SCORE_BITS-1:0] score_i,
  output logic [POS_BITS-1:0]   rd_start_o,
  output logic [POS_BITS-1:0]   rd_end_o,
  output logic [SCORE_BITS-1:0] rd_score_o,
  output logic                  rd_rem_o
);

  logic [POS_BITS-1:0]   start_mem [MAX_ENTRIES];
  logic [POS_BITS-1:0]   end_mem   [MAX_ENTRIES];
  logic [SCORE_BITS-1:0] score_mem [MAX_ENTRIES];
  logic                  rem_mem   [MAX_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_we) begin
      start_mem[waddr_i] <= start_i;
      end_mem[waddr_i]   <= end_i;
      score_mem[waddr_i] <= score_i;
    end
    if (ctl_i.rem_we) begin
      rem_mem[waddr_i] <= ctl_i.rem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_start_o <= start_mem[raddr_i];
      rd_end_o   <= end_mem[raddr_i];
      rd_score_o <= score_mem[raddr_i];
      rd_rem_o   <= rem_mem[raddr_i];
    end
  end

endmodule

@@ hdl/idof_ctrl.sv @@
module idof_ctrl import idof_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned POS_BITS    = 32,
  localparam int unsigned IW         = $clog2(MAX_ENTRIES),
  localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MODE_BITS-1:0]  mode_i,
  idof_in_if.sink               in_ch,
  idof_out_if.source            out_ch,
  output store_ctl_t            st_ctl_o,
  output logic [IW-1:0]         waddr_o,
  output logic [IW-1:0]         raddr_o,
  output logic [POS_BITS-1:0]   wstart_o,
  output logic [POS_BITS-1:0]   wend_o,
  output logic [SCORE_BITS-1:0] wscore_o,
  input  logic [POS_BITS-1:0]   rd_start_i,
  input  logic [POS_BITS-1:0]   rd_end_i,
  input  logic [SCORE_BITS-1:0] rd_score_i,
  input  logic                  rd_rem_i
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_ACAP = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [MODE_BITS-1:0] mode_q, mode_d;
  logic [CW-1:0]        a_q, a_d;
  logic [CW-1:0]        b_q, b_d;
  logic [CW-1:0]        bp_q, bp_d;
  logic [CW-1:0]        e_q, e_d;
  logic                 rem_a_q, rem_a_d;
  logic [POS_BITS-1:0]  span_s_q, span_s_d;
  logic [POS_BITS-1:0]  span_e_q, span_e_d;
  logic                 out_v_q, out_v_d;

  logic [POS_BITS-1:0]   a_start_q, a_end_q;
  logic [SCORE_BITS-1:0] a_score_q;
  logic                  cap_a;
  logic                  out_load;

  logic [CW-1:0] last_idx;
  logic [CW-1:0] n_new;
  logic          in_xfer;
  logic          ovl_a, ovl_span, same_pos;
  logic          last_a;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign last_idx = cnt_q - 1'b1;
  assign n_new    = (cnt_q != FULL) ? cnt_q + 1'b1 : cnt_q;
  assign last_a   = (a_q + 1'b1) == last_idx;
  assign ovl_a    = !((a_end_q < rd_start_i) || (rd_end_i < a_start_q));
  assign ovl_span = !((span_e_q < rd_start_i) || (rd_end_i < span_s_q));
  assign same_pos = (a_start_q == rd_start_i) && (a_end_q == rd_end_i);

  assign wstart_o = POS_BITS'(in_ch.start_pos);
  assign wend_o   = POS_BITS'(in_ch.end_pos);
  assign wscore_o = in_ch.score;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    mode_d    = mode_q;
    a_d       = a_q;
    b_d       = b_q;
    bp_d      = bp_q;
    e_d       = e_q;
    rem_a_d   = rem_a_q;
    span_s_d  = span_s_q;
    span_e_d  = span_e_q;
    st_ctl_o  = '0;
    waddr_o   = '0;
    raddr_o   = '0;
    cap_a     = 1'b0;
    out_load  = 1'b0;
    in_ch.ready = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_xfer) begin
          if (cnt_q != FULL) begin
            st_ctl_o.ent_we    = 1'b1;
            st_ctl_o.rem_we    = 1'b1;
            st_ctl_o.rem_wdata = in_ch.removed_in;
            waddr_o            = cnt_q[IW-1:0];
            cnt_d              = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_ch.last_in) begin
            mode_d = mode_i;
            a_d    = '0;
            e_d    = '0;
            if (n_new == CW'(1) || mode_i == MODE_NONE) begin
              state_d = S_ERD;
            end else begin
              state_d = S_ARD;
            end
          end
        end
      end
      S_ARD: begin
        st_ctl_o.rd_en = 1'b1;
        raddr_o        = a_q[IW-1:0];
        state_d        = S_ACAP;
      end
      S_ACAP: begin
        cap_a   = 1'b1;
        rem_a_d = 1'b0;
        if (rd_rem_i) begin
          a_d     = a_q + 1'b1;
          state_d = last_a ? S_ERD : S_ARD;
        end else begin
          if (mode_q == MODE_CLUSTER) begin
            span_s_d = rd_start_i;
            span_e_d = rd_end_i;
          end
          st_ctl_o.rd_en = 1'b1;
          raddr_o        = IW'(a_q + 1'b1);
          bp_d           = a_q + 1'b1;
          b_d            = a_q + CW'(2);
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (b_q < cnt_q) begin
          st_ctl_o.rd_en = 1'b1;
          raddr_o        = b_q[IW-1:0];
        end
        bp_d = b_q;
        b_d  = b_q + 1'b1;
        if (bp_q == last_idx) begin
          state_d = S_WB;
        end
        if (!rd_rem_i) begin
          unique case (mode_q)
            MODE_EXACT: begin
              if (same_pos) begin
                st_ctl_o.rem_we    = 1'b1;
                st_ctl_o.rem_wdata = 1'b1;
                waddr_o            = bp_q[IW-1:0];
              end
            end
            MODE_BEST: begin
              if (ovl_a) begin
                st_ctl_o.rem_we    = 1'b1;
                st_ctl_o.rem_wdata = 1'b1;
                if (a_score_q >= rd_score_i) begin
                  waddr_o = bp_q[IW-1:0];
                end else begin
                  waddr_o = a_q[IW-1:0];
                  a_d     = a_q + 1'b1;
                  state_d = last_a ? S_ERD : S_ARD;
                end
              end
            end
            MODE_CLUSTER: begin
              if (ovl_span) begin
                if (rd_start_i < span_s_q) span_s_d = rd_start_i;
                if (span_e_q < rd_end_i) span_e_d = rd_end_i;
                rem_a_d            = 1'b1;
                st_ctl_o.rem_we    = 1'b1;
                st_ctl_o.rem_wdata = 1'b1;
                waddr_o            = bp_q[IW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WB: begin
        st_ctl_o.rem_we    = 1'b1;
        st_ctl_o.rem_wdata = rem_a_q;
        waddr_o            = a_q[IW-1:0];
        a_d                = a_q + 1'b1;
        state_d            = last_a ? S_ERD : S_ARD;
      end
      S_ERD: begin
        st_ctl_o.rd_en = 1'b1;
        raddr_o        = e_q[IW-1:0];
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (!out_v_q || out_ch.ready) begin
          out_load = 1'b1;
          if (e_q == last_idx) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            e_d            = e_q + 1'b1;
            st_ctl_o.rd_en = 1'b1;
            raddr_o        = IW'(e_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    priority if (out_load) begin
      out_v_d = 1'b1;
    end else if (out_ch.ready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      mode_q   <= MODE_EXACT;
      a_q      <= '0;
      b_q      <= '0;
      bp_q     <= '0;
      e_q      <= '0;
      rem_a_q  <= 1'b0;
      span_s_q <= '0;
      span_e_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      mode_q   <= mode_d;
      a_q      <= a_d;
      b_q      <= b_d;
      bp_q     <= bp_d;
      e_q      <= e_d;
      rem_a_q  <= rem_a_d;
      span_s_q <= span_s_d;
      span_e_q <= span_e_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_a) begin
      a_start_q <= rd_start_i;
      a_end_q   <= rd_end_i;
      a_score_q <= rd_score_i;
    end
    if (out_load) begin
      out_ch.entry_index <= IDX_BITS'(e_q);
      out_ch.start_out   <= COORD_BITS'(rd_start_i);
      out_ch.end_out     <= COORD_BITS'(rd_end_i);
      out_ch.removed_out <= rd_rem_i;
      out_ch.overflowed  <= ovf_q;
      out_ch.last_out    <= (e_q == last_idx);
    end
  end

  assign out_ch.valid = out_v_q;

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_ctl_o.rem_we && st_ctl_o.rd_en) |-> (waddr_o != raddr_o))
    else $error("flag write hits the entry being read");

  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cnt_q == FULL) |=> ovf_q)
    else $error("dropped transfer did not flag overflow");

  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_LOAD) |=> (cnt_q == '0 && !ovf_q))
    else $error("batch state not cleared after last result");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (bp_q < cnt_q && a_q < bp_q))
    else $error("scan index out of order");
`endif

endmodule
